### src/lc3_pkg.sv
// Shared types, codes and helpers for the LC-3 execution block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lc3_pkg;

  localparam int unsigned WORD_BITS = 16;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_BITS  = 3;
  localparam int unsigned CFG_BITS  = 1;

  localparam logic [WORD_BITS-1:0] START_RESET = 16'd12288;
  localparam logic [WORD_BITS-1:0] HALT_RESET  = 16'd1172;

  localparam logic [CFG_BITS-1:0] CFG_START = 1'b0;
  localparam logic [CFG_BITS-1:0] CFG_HALT  = 1'b1;

  localparam logic [REG_BITS-1:0] LINK_REG = 3'd7;

  localparam logic [1:0] CC_NEG  = 2'd0;
  localparam logic [1:0] CC_ZERO = 2'd1;
  localparam logic [1:0] CC_POS  = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_EXEC    = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_BR   = 4'd0,
    OP_ADD  = 4'd1,
    OP_LD   = 4'd2,
    OP_ST   = 4'd3,
    OP_JSR  = 4'd4,
    OP_AND  = 4'd5,
    OP_LDR  = 4'd6,
    OP_STR  = 4'd7,
    OP_RTI  = 4'd8,
    OP_NOT  = 4'd9,
    OP_LDI  = 4'd10,
    OP_STI  = 4'd11,
    OP_JMP  = 4'd12,
    OP_RES  = 4'd13,
    OP_LEA  = 4'd14,
    OP_TRAP = 4'd15
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_FETCH,
    ST_DECODE,
    ST_MEM1,
    ST_MEM2
  } state_e;

  typedef struct packed {
    cmd_e                 command;
    logic [WORD_BITS-1:0] address;
    logic [WORD_BITS-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] pc;
    logic [WORD_BITS-1:0] instr;
    logic [1:0]           cond_code;
    logic                 reg_written;
    logic [REG_BITS-1:0]  reg_index;
    logic [WORD_BITS-1:0] reg_value;
    logic [WORD_BITS-1:0] read_data;
    logic                 halted;
  } res_t;

  typedef struct packed {
    logic                 en;
    logic                 we;
    logic [WORD_BITS-1:0] addr;
    logic [WORD_BITS-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic                 rd_en;
    logic [REG_BITS-1:0]  ra;
    logic [REG_BITS-1:0]  rb;
    logic                 we;
    logic [REG_BITS-1:0]  wa;
    logic [WORD_BITS-1:0] wdata;
  } rf_req_t;

  function automatic logic [WORD_BITS-1:0] sext5(input logic [WORD_BITS-1:0] ir);
    return {{11{ir[4]}}, ir[4:0]};
  endfunction

  function automatic logic [WORD_BITS-1:0] sext6(input logic [WORD_BITS-1:0] ir);
    return {{10{ir[5]}}, ir[5:0]};
  endfunction

  function automatic logic [WORD_BITS-1:0] sext9(input logic [WORD_BITS-1:0] ir);
    return {{7{ir[8]}}, ir[8:0]};
  endfunction

  function automatic logic [WORD_BITS-1:0] sext11(input logic [WORD_BITS-1:0] ir);
    return {{5{ir[10]}}, ir[10:0]};
  endfunction

  function automatic logic [1:0] cc_of(input logic [WORD_BITS-1:0] v);
    logic [1:0] cc;
    if (v[WORD_BITS-1]) begin
      cc = CC_NEG;
    end else if (v == '0) begin
      cc = CC_ZERO;
    end else begin
      cc = CC_POS;
    end
    return cc;
  endfunction

endpackage

`default_nettype wire

### src/lc3_mem.sv
// Single-port synchronous word memory with a registered read.
// Depends on lc3_pkg for the request struct.
`default_nettype none

module lc3_mem #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  wire                                 clk_i,
  input  lc3_pkg::mem_req_t                   req_i,
  output logic [lc3_pkg::WORD_BITS-1:0]       rdata_o
);
  import lc3_pkg::*;

  localparam int unsigned DEPTH = 2 ** ADDR_BITS;

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;
  logic [ADDR_BITS-1:0] addr;

  assign addr = req_i.addr[ADDR_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem_q[addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem_q[addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/lc3_regfile.sv
// Eight-entry general register file: one write port, two registered read ports.
// Valid bits make never-written registers read as zero. Depends on lc3_pkg.
`default_nettype none

module lc3_regfile (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  lc3_pkg::rf_req_t                    req_i,
  output logic [lc3_pkg::WORD_BITS-1:0]       rd_a_o,
  output logic [lc3_pkg::WORD_BITS-1:0]       rd_b_o
);
  import lc3_pkg::*;

  logic [WORD_BITS-1:0] regs_q [NUM_REGS];
  logic [NUM_REGS-1:0]  valid_q;
  logic [WORD_BITS-1:0] rd_a_q;
  logic [WORD_BITS-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      regs_q[req_i.wa] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.wa] <= 1'b1;
    end
  end

  // Hold read data until the next read request.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_a_q <= valid_q[req_i.ra] ? regs_q[req_i.ra] : '0;
      rd_b_q <= valid_q[req_i.rb] ? regs_q[req_i.rb] : '0;
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

`default_nettype wire

### src/lc3_ctrl.sv
// Command sequencer and execute datapath: PC, condition code, instruction
// register and result register. Drives lc3_mem and lc3_regfile; uses lc3_pkg.
`default_nettype none

module lc3_ctrl (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start_i,
  output logic                                busy_o,
  input  lc3_pkg::cmd_t                       cmd_i,
  output logic                                done_o,
  output lc3_pkg::res_t                       res_o,
  input  wire  [lc3_pkg::WORD_BITS-1:0]       start_addr_i,
  input  wire  [lc3_pkg::WORD_BITS-1:0]       halt_addr_i,
  output lc3_pkg::mem_req_t                   mem_req_o,
  input  wire  [lc3_pkg::WORD_BITS-1:0]       mem_rdata_i,
  output lc3_pkg::rf_req_t                    rf_req_o,
  input  wire  [lc3_pkg::WORD_BITS-1:0]       rf_a_i,
  input  wire  [lc3_pkg::WORD_BITS-1:0]       rf_b_i
);
  import lc3_pkg::*;

  state_e               state_q, state_d;
  logic [WORD_BITS-1:0] pc_q, pc_d;
  logic [1:0]           cc_q, cc_d;
  logic [WORD_BITS-1:0] ir_q, ir_d;
  res_t                 res_q, res_d;
  logic                 done_q, done_d;

  opcode_e              op;
  opcode_e              fetch_op;
  logic [REG_BITS-1:0]  dr;
  logic [WORD_BITS-1:0] npc;
  logic [WORD_BITS-1:0] pc_rel;
  logic [WORD_BITS-1:0] base_rel;
  logic [WORD_BITS-1:0] alu_b;
  logic                 br_taken;
  logic                 accept;

  logic                 fin;
  logic                 wr;
  logic                 setcc;
  logic [REG_BITS-1:0]  widx;
  logic [WORD_BITS-1:0] wval;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] instr_v;

  assign op       = opcode_e'(ir_q[15:12]);
  assign fetch_op = opcode_e'(mem_rdata_i[15:12]);
  assign dr       = ir_q[11:9];
  assign npc      = pc_q + 16'd1;
  assign pc_rel   = npc + sext9(ir_q);
  assign base_rel = rf_a_i + sext6(ir_q);
  assign alu_b    = ir_q[5] ? sext5(ir_q) : rf_b_i;
  assign br_taken = (ir_q[11] && (cc_q == CC_NEG)) ||
                    (ir_q[10] && (cc_q == CC_ZERO)) ||
                    (ir_q[9] && (cc_q == CC_POS));
  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = start_i && !busy_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i.command)
            CMD_READ: state_d = ST_RDWAIT;
            CMD_EXEC: state_d = (pc_q == halt_addr_i) ? ST_IDLE : ST_FETCH;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_RDWAIT: state_d = ST_IDLE;
      ST_FETCH:  state_d = ST_DECODE;
      ST_DECODE: begin
        case (op)
          OP_LD, OP_LDI, OP_LDR, OP_STI, OP_TRAP: state_d = ST_MEM1;
          default:                                state_d = ST_IDLE;
        endcase
      end
      ST_MEM1:  state_d = (op == OP_LDI) ? ST_MEM2 : ST_IDLE;
      ST_MEM2:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory / register file requests
  always_comb begin
    mem_req_o = '0;
    rf_req_o  = '0;
    pc_d      = pc_q;
    cc_d      = cc_q;
    ir_d      = ir_q;
    res_d     = res_q;
    done_d    = 1'b0;
    fin       = 1'b0;
    wr        = 1'b0;
    setcc     = 1'b0;
    widx      = '0;
    wval      = '0;
    rdata     = '0;
    instr_v   = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i.command)
            CMD_LOAD: begin
              mem_req_o.en    = 1'b1;
              mem_req_o.we    = 1'b1;
              mem_req_o.addr  = cmd_i.address;
              mem_req_o.wdata = cmd_i.data;
              fin             = 1'b1;
            end
            CMD_READ: begin
              mem_req_o.en   = 1'b1;
              mem_req_o.addr = cmd_i.address;
            end
            CMD_RESTART: begin
              pc_d = start_addr_i;
              fin  = 1'b1;
            end
            CMD_EXEC: begin
              if (pc_q == halt_addr_i) begin
                fin = 1'b1;
              end else begin
                mem_req_o.en   = 1'b1;
                mem_req_o.addr = pc_q;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      ST_RDWAIT: begin
        rdata = mem_rdata_i;
        fin   = 1'b1;
      end
      ST_FETCH: begin
        // Fetched word addresses the register file directly.
        ir_d           = mem_rdata_i;
        rf_req_o.rd_en = 1'b1;
        rf_req_o.ra    = mem_rdata_i[8:6];
        rf_req_o.rb    = ((fetch_op == OP_ADD) || (fetch_op == OP_AND)) ?
                         mem_rdata_i[2:0] : mem_rdata_i[11:9];
      end
      ST_DECODE: begin
        instr_v = ir_q;
        case (op)
          OP_BR: begin
            pc_d = br_taken ? pc_rel : npc;
            fin  = 1'b1;
          end
          OP_ADD, OP_AND, OP_NOT, OP_LEA: begin
            case (op)
              OP_ADD:  wval = rf_a_i + alu_b;
              OP_AND:  wval = rf_a_i & alu_b;
              OP_NOT:  wval = ~rf_a_i;
              default: wval = pc_rel;
            endcase
            wr    = 1'b1;
            setcc = 1'b1;
            widx  = dr;
            pc_d  = npc;
            fin   = 1'b1;
          end
          OP_LD, OP_LDI, OP_STI: begin
            mem_req_o.en   = 1'b1;
            mem_req_o.addr = pc_rel;
          end
          OP_LDR: begin
            mem_req_o.en   = 1'b1;
            mem_req_o.addr = base_rel;
          end
          OP_TRAP: begin
            mem_req_o.en   = 1'b1;
            mem_req_o.addr = {8'd0, ir_q[7:0]};
          end
          OP_ST, OP_STR: begin
            mem_req_o.en    = 1'b1;
            mem_req_o.we    = 1'b1;
            mem_req_o.addr  = (op == OP_ST) ? pc_rel : base_rel;
            mem_req_o.wdata = rf_b_i;
            pc_d            = npc;
            fin             = 1'b1;
          end
          OP_JMP: begin
            pc_d = rf_a_i;
            fin  = 1'b1;
          end
          OP_JSR: begin
            pc_d = ir_q[11] ? (npc + sext11(ir_q)) : rf_a_i;
            wr   = 1'b1;
            widx = LINK_REG;
            wval = npc;
            fin  = 1'b1;
          end
          default: begin
            pc_d = npc;
            fin  = 1'b1;
          end
        endcase
      end
      ST_MEM1: begin
        instr_v = ir_q;
        case (op)
          OP_LD, OP_LDR: begin
            wr    = 1'b1;
            setcc = 1'b1;
            widx  = dr;
            wval  = mem_rdata_i;
            pc_d  = npc;
            fin   = 1'b1;
          end
          OP_TRAP: begin
            wr   = 1'b1;
            widx = LINK_REG;
            wval = npc;
            pc_d = mem_rdata_i;
            fin  = 1'b1;
          end
          OP_LDI: begin
            mem_req_o.en   = 1'b1;
            mem_req_o.addr = mem_rdata_i;
          end
          OP_STI: begin
            mem_req_o.en    = 1'b1;
            mem_req_o.we    = 1'b1;
            mem_req_o.addr  = mem_rdata_i;
            mem_req_o.wdata = rf_b_i;
            pc_d            = npc;
            fin             = 1'b1;
          end
          default: begin
            pc_d = npc;
            fin  = 1'b1;
          end
        endcase
      end
      ST_MEM2: begin
        instr_v = ir_q;
        wr      = 1'b1;
        setcc   = 1'b1;
        widx    = dr;
        wval    = mem_rdata_i;
        pc_d    = npc;
        fin     = 1'b1;
      end
      default: ;
    endcase

    if (wr) begin
      rf_req_o.we    = 1'b1;
      rf_req_o.wa    = widx;
      rf_req_o.wdata = wval;
      if (setcc) begin
        cc_d = cc_of(wval);
      end
    end

    if (fin) begin
      done_d            = 1'b1;
      res_d.pc          = pc_d;
      res_d.instr       = instr_v;
      res_d.cond_code   = cc_d;
      res_d.reg_written = wr;
      res_d.reg_index   = widx;
      res_d.reg_value   = wval;
      res_d.read_data   = rdata;
      res_d.halted      = (pc_d == halt_addr_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= START_RESET;
      cc_q    <= CC_ZERO;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      cc_q    <= cc_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ir_q  <= ir_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_exec_fetches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i.command == CMD_EXEC) && (pc_q != halt_addr_i))
      |=> (state_q == ST_FETCH))
    else $error("execute command did not start a fetch");

  a_mem2_follows_mem1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MEM2) |-> ($past(state_q) == ST_MEM1))
    else $error("second memory access without a first");

  a_rf_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_req_o.we |-> ((state_q == ST_DECODE) || (state_q == ST_MEM1) ||
                     (state_q == ST_MEM2)))
    else $error("register write outside execute phases");

  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past((state_q != ST_IDLE) || start_i))
    else $error("result strobe without a command in progress");

endmodule

`default_nettype wire

### src/lc3_instruction_execute.sv
// Top level of the LC-3 execution block: configuration registers and the
// sequencer, memory and register file. Depends on lc3_pkg, lc3_ctrl,
// lc3_mem and lc3_regfile.
//
//   channel   handshake                      payload
//   command   start_i / busy_o               cmd_i   (command, address, data)
//   result    done_o (one-cycle strobe)      res_o   (pc ... halted)
//   config    cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// Load, restart and an execute at the halt address finish in IDLE; a read
// also visits RDWAIT. Execute runs FETCH, DECODE for ALU, branch, jump, store;
// LD, LDR, STI, TRAP add MEM1, LDI also MEM2: every access uses the one port.
// Reset clears PC to the start address reset value, the condition code to
// zero and all registers to zero; memory contents stay undefined until loaded.
// busy_o is high while a command is in flight; results cannot be stalled.
`default_nettype none

module lc3_instruction_execute #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start_i,
  output logic                                busy_o,
  input  lc3_pkg::cmd_t                       cmd_i,
  output logic                                done_o,
  output lc3_pkg::res_t                       res_o,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [lc3_pkg::CFG_BITS-1:0]        cfg_index_i,
  input  wire  [lc3_pkg::WORD_BITS-1:0]       cfg_data_i
);
  import lc3_pkg::*;

  logic [WORD_BITS-1:0] start_addr_q;
  logic [WORD_BITS-1:0] halt_addr_q;
  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] mem_rdata;
  rf_req_t              rf_req;
  logic [WORD_BITS-1:0] rf_a;
  logic [WORD_BITS-1:0] rf_b;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_addr_q <= START_RESET;
      halt_addr_q  <= HALT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START: start_addr_q <= cfg_data_i;
        CFG_HALT:  halt_addr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lc3_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .done_o       (done_o),
    .res_o        (res_o),
    .start_addr_i (start_addr_q),
    .halt_addr_i  (halt_addr_q),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .rf_req_o     (rf_req),
    .rf_a_i       (rf_a),
    .rf_b_i       (rf_b)
  );

  lc3_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  lc3_regfile u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rf_req),
    .rd_a_o (rf_a),
    .rd_b_o (rf_b)
  );

endmodule

`default_nettype wire

### sim/tb_lc3_instruction_execute.sv
// Self-checking bench for lc3_instruction_execute: short programs with random content
// are loaded and stepped, and every result is checked against an in-bench LC-3 model.
// Depends on lc3_pkg and the lc3_instruction_execute RTL.
`timescale 1ns / 1ps

module tb_lc3_instruction_execute;
  import lc3_pkg::*;

  localparam int PLAN = 0;  // model copy that runs ahead while stimulus is built
  localparam int LIVE = 1;  // model copy that advances on each accepted command
  localparam int PHASE_ITEMS = 112;
  localparam int STALL_LIMIT = 1000;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  cmd_t                 cmd_i       = '0;
  logic                 cfg_valid_i = 1'b0;
  logic [CFG_BITS-1:0]  cfg_index_i = '0;
  logic [WORD_BITS-1:0] cfg_data_i  = '0;
  logic                 busy_o;
  logic                 done_o;
  res_t                 res_o;
  logic                 cfg_ready_o;

  lc3_instruction_execute u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Machine state, one copy for planning and one for checking
  logic [15:0] mem_w   [2][65536];
  logic [15:0] gpr     [2][8];
  logic [15:0] pc_r    [2];
  logic [1:0]  cc_r    [2];
  logic [15:0] start_r [2];
  logic [15:0] halt_r  [2];
  bit          written_map [65536];
  logic [15:0] written_list [$];

  cmd_t pending_cmds [$];
  res_t expected_status [$];

  int          planned;
  int          accepted;
  int          results_seen;
  int          failures;
  int          stall_cycles;
  int          burst_left;
  int          gap_left;
  int          exec_count;
  int          halted_steps;
  int          settings;
  int unsigned cmd_count [4];
  logic [15:0] op_seen = '0;

  function automatic logic [15:0] sx(input logic [15:0] v, input int n);
    logic [15:0] m;
    m = (16'h1 << n) - 16'h1;
    v = v & m;
    if (v[n-1]) v = v | ~m;
    return v;
  endfunction

  function automatic void mem_put(input int k, input logic [15:0] a, input logic [15:0] v);
    mem_w[k][a] = v;
    if (k == PLAN && !written_map[a]) begin
      written_map[a] = 1'b1;
      written_list.push_back(a);
    end
  endfunction

  function automatic res_t lc3_step(input int k, input cmd_t c);
    res_t        r;
    logic [15:0] ir, npc, ea, ra, b, t;
    opcode_e     op;
    logic [2:0]  dr, sr1;
    logic        setcc;
    r = '0;
    setcc = 1'b0;
    case (c.command)
      CMD_LOAD: mem_put(k, c.address, c.data);
      CMD_READ: r.read_data = mem_w[k][c.address];
      CMD_RESTART: pc_r[k] = start_r[k];
      default: begin
        if (pc_r[k] != halt_r[k]) begin
          ir  = mem_w[k][pc_r[k]];
          npc = pc_r[k] + 16'h1;
          op  = opcode_e'(ir[15:12]);
          dr  = ir[11:9];
          sr1 = ir[8:6];
          ea  = npc + sx(ir, 9);
          ra  = gpr[k][sr1] + sx(ir, 6);
          r.instr = ir;
          if (k == LIVE) begin
            exec_count++;
            op_seen[ir[15:12]] = 1'b1;
          end
          case (op)
            OP_BR: begin
              if ((ir[11] && cc_r[k] == CC_NEG) || (ir[10] && cc_r[k] == CC_ZERO) ||
                  (ir[9] && cc_r[k] == CC_POS)) npc = ea;
            end
            OP_ADD, OP_AND: begin
              b = ir[5] ? sx(ir, 5) : gpr[k][ir[2:0]];
              r.reg_value = (op == OP_ADD) ? gpr[k][sr1] + b : gpr[k][sr1] & b;
              r.reg_written = 1'b1; r.reg_index = dr; setcc = 1'b1;
            end
            OP_NOT: begin
              r.reg_value = ~gpr[k][sr1];
              r.reg_written = 1'b1; r.reg_index = dr; setcc = 1'b1;
            end
            OP_LD: begin
              r.reg_value = mem_w[k][ea];
              r.reg_written = 1'b1; r.reg_index = dr; setcc = 1'b1;
            end
            OP_LDI: begin
              r.reg_value = mem_w[k][mem_w[k][ea]];
              r.reg_written = 1'b1; r.reg_index = dr; setcc = 1'b1;
            end
            OP_LDR: begin
              r.reg_value = mem_w[k][ra];
              r.reg_written = 1'b1; r.reg_index = dr; setcc = 1'b1;
            end
            OP_LEA: begin
              r.reg_value = ea;
              r.reg_written = 1'b1; r.reg_index = dr; setcc = 1'b1;
            end
            OP_ST:  mem_put(k, ea, gpr[k][dr]);
            OP_STI: mem_put(k, mem_w[k][ea], gpr[k][dr]);
            OP_STR: mem_put(k, ra, gpr[k][dr]);
            OP_JMP: npc = gpr[k][sr1];
            OP_JSR: begin
              // take the target before the link register is overwritten
              t = ir[11] ? npc + sx(ir, 11) : gpr[k][sr1];
              r.reg_value = npc; r.reg_written = 1'b1; r.reg_index = LINK_REG;
              npc = t;
            end
            OP_TRAP: begin
              r.reg_value = npc; r.reg_written = 1'b1; r.reg_index = LINK_REG;
              npc = mem_w[k][{8'h00, ir[7:0]}];
            end
            default: ;
          endcase
          if (r.reg_written) begin
            gpr[k][r.reg_index] = r.reg_value;
            if (setcc) begin
              cc_r[k] = r.reg_value[15] ? CC_NEG : (r.reg_value == 16'h0 ? CC_ZERO : CC_POS);
            end
          end
          pc_r[k] = npc;
        end
      end
    endcase
    r.pc        = pc_r[k];
    r.cond_code = cc_r[k];
    r.halted    = (pc_r[k] == halt_r[k]);
    return r;
  endfunction

  function automatic opcode_e pick_op();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 14) return OP_ADD;
    if (w < 24) return OP_AND;
    if (w < 30) return OP_NOT;
    if (w < 36) return OP_LEA;
    if (w < 44) return OP_LD;
    if (w < 50) return OP_LDI;
    if (w < 58) return OP_LDR;
    if (w < 66) return OP_ST;
    if (w < 71) return OP_STI;
    if (w < 78) return OP_STR;
    if (w < 88) return OP_BR;
    if (w < 91) return OP_JMP;
    if (w < 95) return OP_JSR;
    if (w < 98) return OP_TRAP;
    if (w < 99) return OP_RTI;
    return OP_RES;
  endfunction

  function automatic logic [15:0] rand_instr(input opcode_e op);
    logic [15:0] ir;
    ir = $urandom;
    ir[15:12] = op;
    // keep most branches short so that loops form
    if (op == OP_BR && $urandom_range(0, 3) != 0) ir[8:0] = $urandom_range(0, 16) - 8;
    if (op == OP_JSR && $urandom_range(0, 3) != 0) ir[10:0] = $urandom_range(0, 32) - 16;
    return ir;
  endfunction

  task automatic queue_cmd(input cmd_e op, input logic [15:0] a, input logic [15:0] d);
    cmd_t c;
    c.command = op;
    c.address = a;
    c.data    = d;
    pending_cmds.push_back(c);
    void'(lc3_step(PLAN, c));
    planned++;
  endtask

  task automatic need(input logic [15:0] a);
    if (!written_map[a]) queue_cmd(CMD_LOAD, a, $urandom);
  endtask

  // Load every word that the instruction at the current PC is going to read
  task automatic load_operands(input logic [15:0] ir);
    logic [15:0] ea;
    ea = pc_r[PLAN] + 16'h1 + sx(ir, 9);
    case (opcode_e'(ir[15:12]))
      OP_LD, OP_STI: need(ea);
      OP_LDI: begin
        need(ea);
        need(mem_w[PLAN][ea]);
      end
      OP_LDR:  need(gpr[PLAN][ir[8:6]] + sx(ir, 6));
      OP_TRAP: need({8'h00, ir[7:0]});
      default: ;
    endcase
  endtask

  task automatic queue_exec_word(input logic [15:0] ir, input bit fresh);
    if (pc_r[PLAN] != halt_r[PLAN]) begin
      if (fresh) queue_cmd(CMD_LOAD, pc_r[PLAN], ir);
      load_operands(mem_w[PLAN][pc_r[PLAN]]);
    end
    queue_cmd(CMD_EXEC, $urandom, $urandom);
  endtask

  task automatic queue_random(input int n);
    int          target;
    int unsigned pick;
    target = planned + n;
    while (planned < target) begin
      pick = $urandom_range(0, 99);
      if (pc_r[PLAN] == halt_r[PLAN] && pick < 40) begin
        queue_cmd(CMD_RESTART, $urandom, $urandom);
      end else if (pick < 5) begin
        queue_cmd(CMD_RESTART, $urandom, $urandom);
      end else if (pick < 12 && written_list.size() != 0) begin
        queue_cmd(CMD_READ, written_list[$urandom_range(0, written_list.size() - 1)],
                  $urandom);
      end else if (pick < 17) begin
        queue_cmd(CMD_LOAD, $urandom, $urandom);
      end else if (pick < 30 && written_map[pc_r[PLAN]]) begin
        // rerun whatever already sits at the PC
        queue_exec_word(16'h0, 1'b0);
      end else begin
        queue_exec_word(rand_instr(pick_op()), 1'b1);
      end
    end
  endtask

  task automatic write_register(input logic [CFG_BITS-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    for (int k = 0; k < 2; k++) begin
      if (idx == CFG_START) start_r[k] = val;
      else halt_r[k] = val;
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [15:0] s, h;
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 8; i++) gpr[k][i] = 16'h0;
      pc_r[k]    = START_RESET;
      cc_r[k]    = CC_ZERO;
      start_r[k] = START_RESET;
      halt_r[k]  = HALT_RESET;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        queue_cmd(CMD_LOAD, 16'h0000, 16'hFFFF);
        queue_cmd(CMD_LOAD, 16'hFFFF, 16'h0000);
        queue_cmd(CMD_READ, 16'hFFFF, 16'h0000);
        queue_cmd(CMD_READ, 16'h0000, 16'hFFFF);
        queue_cmd(CMD_RESTART, 16'hFFFF, 16'hFFFF);
        queue_exec_word({OP_ADD, 3'd1, 3'd0, 1'b1, 5'h10}, 1'b1);
        queue_exec_word({OP_NOT, 3'd3, 3'd1, 6'h3F}, 1'b1);
        queue_exec_word({OP_LD, 3'd5, 9'h100}, 1'b1);
        queue_exec_word({OP_JSR, 1'b1, 11'h400}, 1'b1);
        // jump through the link register itself
        queue_exec_word({OP_JSR, 1'b0, 2'b00, 3'd7, 6'h00}, 1'b1);
        queue_exec_word({OP_TRAP, 4'h0, 8'h00}, 1'b1);
        // run the words at the top and bottom of memory so the PC wraps
        if (written_map[pc_r[PLAN]]) queue_exec_word(16'h0, 1'b0);
        if (written_map[pc_r[PLAN]]) queue_exec_word(16'h0, 1'b0);
        queue_exec_word({OP_RTI, 12'h000}, 1'b1);
        queue_exec_word({OP_RES, 12'hFFF}, 1'b1);
      end else begin
        case (ph)
          1: begin s = 16'h0000; h = 16'hFFFF; end
          2: begin s = 16'hFFFF; h = 16'h0000; end
          3: begin s = 16'h4000; h = 16'h4006; end
          4: begin s = $urandom; h = s + $urandom_range(2, 10); end
          default: begin s = $urandom; h = s; end
        endcase
        write_register(CFG_START, s);
        write_register(CFG_HALT, h);
        settings++;
        queue_cmd(CMD_RESTART, $urandom, $urandom);
        queue_exec_word(rand_instr(pick_op()), 1'b1);
      end
      queue_random(PHASE_ITEMS);
      // drain before the next register write
      do @(posedge clk_i); while (accepted != planned || expected_status.size() != 0);
      repeat (8) @(posedge clk_i);
    end

    repeat (20) @(posedge clk_i);
    failures += expected_status.size();
    $display("%0d commands: %0d load, %0d read, %0d restart, %0d execute; %0d results checked",
             accepted, cmd_count[CMD_LOAD], cmd_count[CMD_READ], cmd_count[CMD_RESTART],
             cmd_count[CMD_EXEC], results_seen);
    $display("%0d instructions over %0d of 16 opcodes, %0d halted steps, %0d register settings",
             exec_count, $countones(op_seen), halted_steps, settings + 1);
    if (failures == 0) begin
      $display("lc3_instruction_execute regression: pass");
    end else begin
      $display("lc3_instruction_execute regression: fail");
    end
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    res_t r;
    if (!rst_ni) begin
      start_i <= 1'b0;
      cmd_i   <= '0;
    end else begin
      if (start_i && !busy_o) begin
        r = lc3_step(LIVE, cmd_i);
        expected_status.push_back(r);
        cmd_count[cmd_i.command]++;
        if (cmd_i.command == CMD_EXEC && r.halted) halted_steps++;
        accepted++;
      end
      // hold the command while the block is busy
      if (!start_i || !busy_o) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd_i   <= pending_cmds.pop_front();
          start_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    res_t  want;
    string bad;
    if (rst_ni && done_o === 1'b1) begin
      results_seen++;
      if (expected_status.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result %0d arrived with nothing expected: pc=%h",
                                     results_seen, res_o.pc);
      end else begin
        want = expected_status.pop_front();
        bad = "";
        if (res_o.pc !== want.pc) bad = {bad, " pc"};
        if (res_o.instr !== want.instr) bad = {bad, " instr"};
        if (res_o.cond_code !== want.cond_code) bad = {bad, " cond_code"};
        if (res_o.reg_written !== want.reg_written) bad = {bad, " reg_written"};
        if (res_o.reg_index !== want.reg_index) bad = {bad, " reg_index"};
        if (res_o.reg_value !== want.reg_value) bad = {bad, " reg_value"};
        if (res_o.read_data !== want.read_data) bad = {bad, " read_data"};
        if (res_o.halted !== want.halted) bad = {bad, " halted"};
        if (bad != "") begin
          failures++;
          if (failures <= 10) begin
            $display("result %0d wrong in%s: expected pc=%h ir=%h cc=%0d wr=%0b r%0d=%h rd=%h h=%0b",
                     results_seen, bad, want.pc, want.instr, want.cond_code, want.reg_written,
                     want.reg_index, want.reg_value, want.read_data, want.halted);
            $display("  got pc=%h ir=%h cc=%0d wr=%0b r%0d=%h rd=%h h=%0b",
                     res_o.pc, res_o.instr, res_o.cond_code, res_o.reg_written,
                     res_o.reg_index, res_o.reg_value, res_o.read_data, res_o.halted);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start_i && !busy_o) || done_o === 1'b1 || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d of %0d commands accepted",
               STALL_LIMIT, accepted, planned);
      $display("lc3_instruction_execute regression: fail");
      $finish;
    end
  end

endmodule

### filelist.f
src/lc3_pkg.sv
src/lc3_mem.sv
src/lc3_regfile.sv
src/lc3_ctrl.sv
src/lc3_instruction_execute.sv
sim/tb_lc3_instruction_execute.sv
